[hw/rtl/nmea_sentence_validator_defines.svh]
// assertion macros for the checker file of the sentence validator
// no dependencies; expects clk_i and rst_ni in the scope of each use
`ifndef NMEA_SENTENCE_VALIDATOR_DEFINES_SVH
`define NMEA_SENTENCE_VALIDATOR_DEFINES_SVH

// concurrent check on the rising clock, off while reset is held
`define NSV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen
`define NSV_ASSERT_NEVER(name, cond, msg) \
  `NSV_ASSERT(name, !(cond), msg)

`endif

[hw/rtl/nsv_pkg.sv]
// package of the nmea sentence validator: character codes, status codes, hex decode
// no dependencies
package nsv_pkg;

  // character codes
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;

  // identifier and tail geometry
  localparam int ID_LEN      = 5;
  localparam int ID_W        = 8 * ID_LEN;
  localparam int TAIL_W      = 24;
  localparam int COMMA_W     = 5;
  localparam int NO_COMMA_LEN = ID_LEN + 4;  // '$', identifier, '*', two digits

  // output word layout
  localparam int STATUS_W = 3;
  localparam int OUT_W    = 56;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_NO_START    = 3'd2,
    ST_NO_CHECKSUM = 3'd3,
    ST_BAD_HEX     = 3'd4,
    ST_MISMATCH    = 3'd5,
    ST_BAD_ID      = 3'd6,
    ST_TOO_MANY    = 3'd7
  } status_e;

  // hex digit decode: bit 4 set for a valid digit, nibble below
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

[hw/rtl/nmea_sentence_validator.sv]
// nmea sentence validator top level: running checks on a byte stream, one result per sentence
// depends on nsv_pkg
//
// Sentence bytes arrive one per word on the slave stream, tlast marking the final byte; the
// block gives one result word on the master stream at each final byte and none otherwise.
// One byte is taken in every cycle: each byte passes an input register, then a single pass of
// running updates (xor, length, comma count, last three bytes) into the state and, at the
// final byte, into the result register. Only a final byte can wait in the input register, and
// only while the result register still holds an untaken result; the input stalls only behind
// such a waiting final byte. Trailing CR/LF bytes are ignored. The state clears itself after
// each final byte, so no sentence buffer is kept.
module nmea_sentence_validator #(
  parameter int MAX_FIELDS = 16,
  parameter int MAX_LEN    = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [nsv_pkg::OUT_W-1:0] m_axis_tdata
  // m_axis_tdata: status[2:0], identifier[42:3], field_count[47:43], body_checksum[55:48]
);
  import nsv_pkg::*;

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam logic [PW-1:0] MaxLen = PW'(MAX_LEN);
  localparam logic [PW-1:0] IdPos  = PW'(ID_LEN + 1);
  localparam logic [PW-1:0] NoCommaLen = PW'(NO_COMMA_LEN);
  localparam logic [COMMA_W-1:0] MaxFields = COMMA_W'(MAX_FIELDS);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       advance;

  // running state
  logic [PW-1:0]      pos_q, pos_d;
  logic [PW-1:0]      clen_q, clen_d;
  logic               dollar_q, dollar_d;
  logic [7:0]         txor_q, txor_d;
  logic [7:0]         trail_q, trail_d;
  logic [TAIL_W-1:0]  recent_q, recent_d;
  logic [TAIL_W-1:0]  tail_q, tail_d;
  logic [PW-1:0]      fcomma_q, fcomma_d;
  logic [COMMA_W-1:0] commas_q, commas_d;
  logic [ID_W-1:0]    id_q, id_d;

  // result
  logic               out_valid_q;
  status_e            status_d, status_q;
  logic [ID_W-1:0]    ident_d, ident_q;
  logic [COMMA_W-1:0] fields_d, fields_q;
  logic [7:0]         body_d, body_q;

  logic       is_comma, is_crlf;
  logic [7:0] t0, t1, t2;
  logic [4:0] hi, lo;

  // a final byte moves on only when the result register is free or being emptied
  assign advance = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // per-byte state update
  always_comb begin
    is_comma = (in_byte_q == CHAR_COMMA);
    is_crlf  = (in_byte_q == CHAR_CR) || (in_byte_q == CHAR_LF);
    dollar_d = (pos_q == '0) ? (in_byte_q == CHAR_DOLLAR) : dollar_q;
    id_d     = (pos_q != '0 && pos_q < IdPos) ? {id_q[ID_W-9:0], in_byte_q} : id_q;
    fcomma_d = (is_comma && fcomma_q == '0 && pos_q != '0) ? pos_q : fcomma_q;
    commas_d = (is_comma && commas_q <= MaxFields) ? commas_q + COMMA_W'(1) : commas_q;
    txor_d   = txor_q ^ in_byte_q;
    recent_d = {recent_q[TAIL_W-9:0], in_byte_q};
    if (is_crlf) begin
      trail_d = trail_q ^ in_byte_q;
      tail_d  = tail_q;
      clen_d  = clen_q;
    end else begin
      trail_d = 8'd0;
      tail_d  = recent_d;
      clen_d  = (pos_q == MaxLen) ? pos_q : pos_q + PW'(1);
    end
    pos_d = (pos_q < MaxLen) ? pos_q + PW'(1) : pos_q;
  end

  // sentence checks on the updated state
  always_comb begin
    t0 = tail_d[23:16];
    t1 = tail_d[15:8];
    t2 = tail_d[7:0];
    hi = hex_decode(t1);
    lo = hex_decode(t2);
    body_d   = 8'd0;
    status_d = ST_OK;
    if (clen_d == '0) begin
      status_d = ST_EMPTY;
    end else if (!dollar_d) begin
      status_d = ST_NO_START;
    end else if (t0 != CHAR_STAR || t1 == CHAR_STAR || t2 == CHAR_STAR) begin
      status_d = ST_NO_CHECKSUM;
    end else begin
      body_d = txor_d ^ trail_d ^ CHAR_DOLLAR ^ CHAR_STAR ^ t1 ^ t2;
      if (!hi[4] || !lo[4]) begin
        status_d = ST_BAD_HEX;
      end else if (body_d != {hi[3:0], lo[3:0]}) begin
        status_d = ST_MISMATCH;
      end else if (fcomma_d == '0) begin
        status_d = (clen_d == NoCommaLen) ? ST_OK : ST_BAD_ID;
      end else if (fcomma_d != IdPos) begin
        status_d = ST_BAD_ID;
      end else if (commas_d > MaxFields) begin
        status_d = ST_TOO_MANY;
      end
    end
    ident_d  = (status_d == ST_OK) ? id_d : '0;
    fields_d = (status_d == ST_OK) ? commas_d : '0;
  end

  // control and running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      clen_q      <= '0;
      dollar_q    <= 1'b0;
      txor_q      <= 8'd0;
      trail_q     <= 8'd0;
      recent_q    <= '0;
      tail_q      <= '0;
      fcomma_q    <= '0;
      commas_q    <= '0;
      id_q        <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance && in_last_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        if (in_last_q) begin
          pos_q    <= '0;
          clen_q   <= '0;
          dollar_q <= 1'b0;
          txor_q   <= 8'd0;
          trail_q  <= 8'd0;
          recent_q <= '0;
          tail_q   <= '0;
          fcomma_q <= '0;
          commas_q <= '0;
          id_q     <= '0;
        end else begin
          pos_q    <= pos_d;
          clen_q   <= clen_d;
          dollar_q <= dollar_d;
          txor_q   <= txor_d;
          trail_q  <= trail_d;
          recent_q <= recent_d;
          tail_q   <= tail_d;
          fcomma_q <= fcomma_d;
          commas_q <= commas_d;
          id_q     <= id_d;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && in_last_q) begin
      status_q <= status_d;
      ident_q  <= ident_d;
      fields_q <= fields_d;
      body_q   <= body_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {body_q, fields_q, ident_q, status_q};

endmodule

[hw/rtl/nsv_assert_checker.sv]
// port-level checks on the result stream of the nmea sentence validator, bound to the top
// depends on nsv_pkg and nmea_sentence_validator_defines.svh
`include "nmea_sentence_validator_defines.svh"

module nsv_assert_checker #(
  parameter int MAX_FIELDS = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [nsv_pkg::OUT_W-1:0] m_axis_tdata
);
  import nsv_pkg::*;

  logic [2:0]  status;
  logic [39:0] ident;
  logic [4:0]  fields;
  logic [7:0]  body;

  // unpack the result word
  assign status = m_axis_tdata[2:0];
  assign ident  = m_axis_tdata[42:3];
  assign fields = m_axis_tdata[47:43];
  assign body   = m_axis_tdata[55:48];

  // a stalled result word holds
  `NSV_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

  // identifier and field count only on a good sentence
  `NSV_ASSERT_NEVER(a_fail_clean, m_axis_tvalid && status != ST_OK && (ident != '0 || fields != '0), "failed sentence carries identifier or fields")

  // field count within limit
  `NSV_ASSERT_NEVER(a_field_limit, m_axis_tvalid && fields > 5'(MAX_FIELDS), "field count above limit")

  // no body defined before the checksum check
  `NSV_ASSERT_NEVER(a_body_undefined, m_axis_tvalid && (status == ST_EMPTY || status == ST_NO_START || status == ST_NO_CHECKSUM) && body != 8'd0, "body checksum set without a body")

endmodule

bind nmea_sentence_validator nsv_assert_checker #(.MAX_FIELDS(MAX_FIELDS)) u_nsv_assert_checker (.*);

[sim/nmea_sentence_validator_tb.sv]
// self-checking testbench of the nmea sentence validator: directed sentences, then random traffic
// depends on nsv_pkg and nmea_sentence_validator; no files or arguments are read
module nmea_sentence_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nsv_pkg::*;

  localparam int MAX_FIELDS   = 16;
  localparam int MAX_LEN      = 255;
  localparam int RANDOM_BYTES = 1500;
  localparam int HOLD_CYCLES  = 300;

  typedef logic [7:0] byte_q_t [$];

  typedef enum int {
    SUM_NONE,
    SUM_UPPER,
    SUM_LOWER
  } sum_mode_e;

  // one checker verdict, status in the low bits as on the output word
  typedef struct packed {
    logic [7:0]  body_sum;
    logic [4:0]  fields;
    logic [39:0] ident;
    status_e     status;
  } verdict_t;

  // one byte to send, with a hand-written verdict where the sentence is simple
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    verdict_t   typed_v;
  } stream_word_t;

  typedef struct {
    string     text;
    int        pad_commas;
    sum_mode_e sum_mode;
    string     trailer;
    bit        typed;
    status_e   typed_status;
  } sentence_row_t;

  localparam int NUM_ROWS = 20;

  // directed sentences; status typed in only where it is obvious, the rest predicted
  sentence_row_t dir_rows [NUM_ROWS] = '{
    '{"",              0,  SUM_NONE,  "\015\012", 1'b1, ST_EMPTY},
    '{"",              0,  SUM_NONE,  "\012",     1'b1, ST_EMPTY},
    '{"GPGGA*56",      0,  SUM_NONE,  "",         1'b1, ST_NO_START},
    '{",$GPGGA",       0,  SUM_NONE,  "",         1'b1, ST_NO_START},
    '{"$*",            0,  SUM_NONE,  "",         1'b1, ST_NO_CHECKSUM},
    '{"$GPGGA,1*4",    0,  SUM_NONE,  "\015\012", 1'b1, ST_NO_CHECKSUM},
    '{"$AB**1",        0,  SUM_NONE,  "",         1'b1, ST_NO_CHECKSUM},
    '{"$AB*1*",        0,  SUM_NONE,  "",         1'b1, ST_NO_CHECKSUM},
    '{"$GPGGA*G0",     0,  SUM_NONE,  "",         1'b0, ST_OK},
    '{"$GPGGA*0g",     0,  SUM_NONE,  "",         1'b0, ST_OK},
    '{"$GPGGA*00",     0,  SUM_NONE,  "",         1'b0, ST_OK},
    '{"$GPGGA",        0,  SUM_UPPER, "",         1'b0, ST_OK},
    '{"$gpzda",        0,  SUM_LOWER, "\015\012", 1'b0, ST_OK},
    '{"$GPRMC,1,2,,3", 0,  SUM_UPPER, "\015\012", 1'b0, ST_OK},
    '{"$GP,A",         0,  SUM_UPPER, "",         1'b0, ST_OK},
    '{"$GPGGAX",       0,  SUM_LOWER, "",         1'b0, ST_OK},
    '{"$GPGSV",        16, SUM_UPPER, "",         1'b0, ST_OK},
    '{"$GPGSV",        17, SUM_UPPER, "\012",     1'b0, ST_OK},
    '{"$GP\015\012GGA,1", 0, SUM_UPPER, "\012",   1'b0, ST_OK},
    '{"$~~~~~,\177",   0,  SUM_LOWER, "",         1'b0, ST_OK}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = 8'h00;
  logic             s_axis_tlast  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  stream_word_t word_fifo [$];
  stream_word_t cur_word = '0;
  verdict_t     verdict_q [$];

  int mismatches     = 0;
  int sentences_done = 0;
  int bytes_sent     = 0;
  int status_seen [8];
  int send_idle_pct  = 30;
  int recv_idle_pct  = 30;

  // sentence checker state kept alongside the block
  int          pos_cnt;
  int          content_len;
  int          comma_pos;
  int          comma_cnt;
  logic        dollar_first;
  logic [7:0]  xor_all;
  logic [7:0]  crlf_xor;
  logic [23:0] last3_raw;
  logic [23:0] last3_content;
  logic [39:0] id_reg;

  nmea_sentence_validator #(
    .MAX_FIELDS(MAX_FIELDS),
    .MAX_LEN   (MAX_LEN)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void clear_checker();
    pos_cnt       = 0;
    content_len   = 0;
    comma_pos     = 0;
    comma_cnt     = 0;
    dollar_first  = 1'b0;
    xor_all       = 8'h00;
    crlf_xor      = 8'h00;
    last3_raw     = '0;
    last3_content = '0;
    id_reg        = '0;
  endfunction

  // 0..15 for a hex digit of either case, 16 otherwise
  function automatic int nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return 16;
  endfunction

  // running update for one byte; at the final byte works out the verdict and clears
  function automatic bit check_byte(input logic [7:0] b, input logic fin, output verdict_t v);
    int         p;
    int         hi;
    int         lo;
    logic [7:0] t0;
    logic [7:0] t1;
    logic [7:0] t2;
    p = pos_cnt;
    v = '0;
    if (p == 0) dollar_first = (b == CHAR_DOLLAR);
    if (p >= 1 && p <= ID_LEN) id_reg = {id_reg[31:0], b};
    if (b == CHAR_COMMA) begin
      if (comma_pos == 0 && p != 0) comma_pos = p;
      if (comma_cnt <= MAX_FIELDS) comma_cnt++;
    end
    xor_all   = xor_all ^ b;
    last3_raw = {last3_raw[15:0], b};
    // a cr/lf run only counts as content once something follows it
    if (b == CHAR_CR || b == CHAR_LF) begin
      crlf_xor = crlf_xor ^ b;
    end else begin
      crlf_xor      = 8'h00;
      last3_content = last3_raw;
      content_len   = (p + 1 > MAX_LEN) ? MAX_LEN : p + 1;
    end
    if (p < MAX_LEN) pos_cnt = p + 1;
    if (!fin) return 1'b0;

    {t0, t1, t2} = last3_content;
    hi = nibble_of(t1);
    lo = nibble_of(t2);
    if (content_len == 0) begin
      v.status = ST_EMPTY;
    end else if (!dollar_first) begin
      v.status = ST_NO_START;
    end else if (t0 != CHAR_STAR || t1 == CHAR_STAR || t2 == CHAR_STAR) begin
      v.status = ST_NO_CHECKSUM;
    end else begin
      v.body_sum = xor_all ^ crlf_xor ^ CHAR_DOLLAR ^ CHAR_STAR ^ t1 ^ t2;
      if (hi > 15 || lo > 15) begin
        v.status = ST_BAD_HEX;
      end else if (v.body_sum != 8'(hi * 16 + lo)) begin
        v.status = ST_MISMATCH;
      end else if (comma_pos == 0) begin
        v.status = (content_len == NO_COMMA_LEN) ? ST_OK : ST_BAD_ID;
      end else if (comma_pos != ID_LEN + 1) begin
        v.status = ST_BAD_ID;
      end else if (comma_cnt > MAX_FIELDS) begin
        v.status = ST_TOO_MANY;
      end else begin
        v.status = ST_OK;
        v.fields = 5'(comma_cnt);
      end
    end
    if (v.status == ST_OK) v.ident = id_reg;
    else v.fields = '0;
    clear_checker();
    return 1'b1;
  endfunction

  function automatic logic [7:0] nibble_char(logic [3:0] n, bit lower);
    if (n < 10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  // '*' and two hex digits of the xor of everything after the leading byte
  function automatic void append_checksum(ref byte_q_t q, input bit lower);
    logic [7:0] sum;
    sum = 8'h00;
    for (int i = 1; i < q.size(); i++) sum = sum ^ q[i];
    q.push_back(CHAR_STAR);
    q.push_back(nibble_char(sum[7:4], lower));
    q.push_back(nibble_char(sum[3:0], lower));
  endfunction

  // printable field character, now and then any byte at all
  function automatic logic [7:0] field_char();
    if ($urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range('h30, 'h7A));
  endfunction

  function automatic int pick_gap(int pct);
    int r;
    r = $urandom_range(0, 99);
    if (r >= pct) return 0;
    if (r < pct / 8) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t ns] %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_sentence(input byte_q_t q, input bit typed, input status_e st);
    stream_word_t w;
    while (word_fifo.size() > 64) @(posedge clk_i);
    foreach (q[i]) begin
      w         = '0;
      w.data    = q[i];
      w.last    = (i == q.size() - 1);
      w.typed   = typed;
      w.typed_v.status = st;
      word_fifo.push_back(w);
    end
  endtask

  // sender: holds each word until taken, random gaps between words
  initial begin : sender
    int           gap;
    stream_word_t w;
    gap = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && !(s_axis_tvalid && !s_axis_tready)) begin
        if (gap > 0) begin
          gap--;
          s_axis_tvalid <= 1'b0;
        end else if (word_fifo.size() > 0) begin
          w = word_fifo.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= w.data;
          s_axis_tlast  <= w.last;
          cur_word      <= w;
          gap = pick_gap(send_idle_pct);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus two long hold-offs so the block backs up
  initial begin : receiver
    int hold_left;
    int stall_left;
    int holds_done;
    int next_hold_at;
    int g;
    hold_left    = 0;
    stall_left   = 0;
    holds_done   = 0;
    next_hold_at = 30;
    forever begin
      @(posedge clk_i);
      if (holds_done < 2 && sentences_done >= next_hold_at) begin
        hold_left    = HOLD_CYCLES;
        holds_done++;
        next_hold_at += 12;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        g = pick_gap(recv_idle_pct);
        m_axis_tready <= (g == 0);
        stall_left = (g > 0) ? g - 1 : 0;
      end
    end
  end

  // compare each result word with the oldest verdict, then predict from the accepted byte
  always @(posedge clk_i) begin : scoreboard
    verdict_t v;
    verdict_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result word with no sentence pending", 64'(m_axis_tdata), '0);
        end else begin
          want = verdict_q.pop_front();
          status_seen[want.status]++;
          if (m_axis_tdata[2:0] != want.status)
            report_mismatch("status", 64'(m_axis_tdata[2:0]), 64'(want.status));
          if (m_axis_tdata[42:3] != want.ident)
            report_mismatch("identifier", 64'(m_axis_tdata[42:3]), 64'(want.ident));
          if (m_axis_tdata[47:43] != want.fields)
            report_mismatch("field count", 64'(m_axis_tdata[47:43]), 64'(want.fields));
          if (m_axis_tdata[55:48] != want.body_sum)
            report_mismatch("body checksum", 64'(m_axis_tdata[55:48]), 64'(want.body_sum));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_sent++;
        if (check_byte(cur_word.data, cur_word.last, v)) begin
          verdict_q.push_back(cur_word.typed ? cur_word.typed_v : v);
          sentences_done++;
        end
      end
    end
  end

  initial begin : main_seq
    byte_q_t sent;
    int      random_bytes;
    int      kind;
    int      n;
    int      phase;
    clear_checker();
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed sentences
    foreach (dir_rows[r]) begin
      sent = {};
      for (int i = 0; i < dir_rows[r].text.len(); i++) sent.push_back(dir_rows[r].text[i]);
      repeat (dir_rows[r].pad_commas) sent.push_back(CHAR_COMMA);
      if (dir_rows[r].sum_mode != SUM_NONE)
        append_checksum(sent, dir_rows[r].sum_mode == SUM_LOWER);
      for (int i = 0; i < dir_rows[r].trailer.len(); i++)
        sent.push_back(dir_rows[r].trailer[i]);
      queue_sentence(sent, dir_rows[r].typed, dir_rows[r].typed_status);
    end

    // random sentences: mostly well formed, some corrupted, some noise
    random_bytes = 0;
    phase        = 0;
    while (random_bytes < RANDOM_BYTES) begin
      if (phase % 25 == 0) begin
        send_idle_pct = ((phase / 25) % 3 == 0) ? 0 : 35;
        recv_idle_pct = ((phase / 25) % 3 == 1) ? 0 : 30;
      end
      phase++;
      sent = {};
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        n = $urandom_range(1, 12);
        repeat (n) sent.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 10) begin
        n = $urandom_range(1, 3);
        repeat (n) sent.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      end else begin
        sent.push_back(CHAR_DOLLAR);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 7) : ID_LEN;
        repeat (n) sent.push_back(8'h41 + 8'($urandom_range(0, 25)));
        if ($urandom_range(0, 59) == 0) begin
          // long sentence past the length limit, with or without a field
          if ($urandom_range(0, 1)) sent.push_back(CHAR_COMMA);
          n = $urandom_range(250, 300);
          repeat (n) sent.push_back(field_char());
        end else begin
          n = ($urandom_range(0, 6) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 16);
          repeat (n) begin
            sent.push_back(CHAR_COMMA);
            repeat ($urandom_range(0, 6)) sent.push_back(field_char());
          end
        end
        append_checksum(sent, $urandom_range(0, 1));
        if (kind < 30) begin
          sent[$urandom_range(0, sent.size() - 1)] = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, sent.size());
            while (sent.size() > n) void'(sent.pop_back());
          end
        end
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 3)) sent.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
        end
      end
      random_bytes += sent.size();
      queue_sentence(sent, 1'b0, ST_OK);
    end

    // drain: every byte taken, every verdict matched, then a few quiet cycles
    while (word_fifo.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d sentences in %0d bytes, with idle gaps and long output stalls",
             sentences_done, bytes_sent);
    $display("Verdicts by status code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d verdicts outstanding", verdict_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
